/* hdl/bre_pkg.sv */
// Shared widths, codes and the micro-program of the body-rate integrator.
package bre_pkg;

  localparam int RATE_W  = 32;
  localparam int MOM_W   = 48;
  localparam int INR_W   = 48;
  localparam int STEP_W  = 24;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 3;

  localparam int ACC_W   = 116;
  localparam int PACC_W  = 114;
  localparam int MA_W    = 65;
  localparam int MBS_W   = 50;
  localparam int DIG_W   = 8;
  localparam int MB_W    = 56;
  localparam int MUL_STEPS = MB_W / DIG_W;
  localparam int DEN_W   = 97;
  localparam int NUM_W   = 121;
  localparam int DSH_W   = 128;
  localparam int QUO_W   = 32;
  localparam int PC_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_IXX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IYY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IZZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IXZ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 3'd4;

  localparam logic [INR_W-1:0]  INR_RST  = 48'd65536;
  localparam logic [STEP_W-1:0] STEP_RST = 24'd139810;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RSVD = 2'd3;

  // micro-op kinds
  localparam logic [2:0] K_MUL = 3'd0;
  localparam logic [2:0] K_SET = 3'd1;
  localparam logic [2:0] K_ST  = 3'd2;
  localparam logic [2:0] K_CHK = 3'd3;
  localparam logic [2:0] K_DIV = 3'd4;
  localparam logic [2:0] K_UPD = 3'd5;
  localparam logic [2:0] K_END = 3'd6;

  // accumulate modes
  localparam logic [1:0] M_LD  = 2'd0;
  localparam logic [1:0] M_ADD = 2'd1;
  localparam logic [1:0] M_SUB = 2'd2;

  // A operand
  localparam logic [3:0] A_P    = 4'd0;
  localparam logic [3:0] A_Q    = 4'd1;
  localparam logic [3:0] A_R    = 4'd2;
  localparam logic [3:0] A_PQ   = 4'd3;
  localparam logic [3:0] A_QR   = 4'd4;
  localparam logic [3:0] A_PR   = 4'd5;
  localparam logic [3:0] A_D2   = 4'd6;
  localparam logic [3:0] A_IXX  = 4'd7;
  localparam logic [3:0] A_IXZ  = 4'd8;
  localparam logic [3:0] A_TL   = 4'd9;
  localparam logic [3:0] A_TN   = 4'd10;
  localparam logic [3:0] A_SUM0 = 4'd11;
  localparam logic [3:0] A_SUM1 = 4'd12;
  localparam logic [3:0] A_SUM2 = 4'd13;

  // B operand
  localparam logic [3:0] B_P    = 4'd0;
  localparam logic [3:0] B_Q    = 4'd1;
  localparam logic [3:0] B_R    = 4'd2;
  localparam logic [3:0] B_IXX  = 4'd3;
  localparam logic [3:0] B_IZZ  = 4'd4;
  localparam logic [3:0] B_IXZ  = 4'd5;
  localparam logic [3:0] B_ZY   = 4'd6;
  localparam logic [3:0] B_XZ   = 4'd7;
  localparam logic [3:0] B_YX   = 4'd8;
  localparam logic [3:0] B_STEP = 4'd9;

  // store targets
  localparam logic [2:0] D_PQ  = 3'd0;
  localparam logic [2:0] D_QR  = 3'd1;
  localparam logic [2:0] D_PR  = 3'd2;
  localparam logic [2:0] D_D2  = 3'd3;
  localparam logic [2:0] D_DEN = 3'd4;
  localparam logic [2:0] D_TL  = 3'd5;
  localparam logic [2:0] D_TM  = 3'd6;
  localparam logic [2:0] D_TN  = 3'd7;

  // accumulator preload sources
  localparam logic [2:0] S_ML = 3'd0;
  localparam logic [2:0] S_MM = 3'd1;
  localparam logic [2:0] S_MN = 3'd2;
  localparam logic [2:0] S_TM = 3'd3;

  localparam logic [PC_W-1:0] PC_END = 6'd39;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] mode;
    logic [3:0] asel;
    logic [3:0] bsel;
    logic [2:0] arg;
  } uop_t;

  function automatic uop_t mk(logic [2:0] kind, logic [1:0] mode, logic [3:0] asel,
                              logic [3:0] bsel, logic [2:0] arg);
    uop_t u;
    u.kind = kind;
    u.mode = mode;
    u.asel = asel;
    u.bsel = bsel;
    u.arg  = arg;
    return u;
  endfunction

  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(K_MUL, M_LD,  A_P,    B_Q,    3'd0);
      6'd1:  u = mk(K_ST,  M_LD,  A_P,    B_P,    D_PQ);
      6'd2:  u = mk(K_MUL, M_LD,  A_Q,    B_R,    3'd0);
      6'd3:  u = mk(K_ST,  M_LD,  A_P,    B_P,    D_QR);
      6'd4:  u = mk(K_MUL, M_LD,  A_P,    B_R,    3'd0);
      6'd5:  u = mk(K_ST,  M_LD,  A_P,    B_P,    D_PR);
      6'd6:  u = mk(K_MUL, M_LD,  A_P,    B_P,    3'd0);
      6'd7:  u = mk(K_MUL, M_SUB, A_R,    B_R,    3'd0);
      6'd8:  u = mk(K_ST,  M_LD,  A_P,    B_P,    D_D2);
      6'd9:  u = mk(K_MUL, M_LD,  A_IXX,  B_IZZ,  3'd0);
      6'd10: u = mk(K_MUL, M_SUB, A_IXZ,  B_IXZ,  3'd0);
      6'd11: u = mk(K_ST,  M_LD,  A_P,    B_P,    D_DEN);
      6'd12: u = mk(K_CHK, M_LD,  A_P,    B_P,    3'd0);
      6'd13: u = mk(K_SET, M_LD,  A_P,    B_P,    S_ML);
      6'd14: u = mk(K_MUL, M_ADD, A_PQ,   B_IXZ,  3'd0);
      6'd15: u = mk(K_MUL, M_SUB, A_QR,   B_ZY,   3'd0);
      6'd16: u = mk(K_ST,  M_LD,  A_P,    B_P,    D_TL);
      6'd17: u = mk(K_SET, M_LD,  A_P,    B_P,    S_MM);
      6'd18: u = mk(K_MUL, M_SUB, A_PR,   B_XZ,   3'd0);
      6'd19: u = mk(K_MUL, M_SUB, A_D2,   B_IXZ,  3'd0);
      6'd20: u = mk(K_ST,  M_LD,  A_P,    B_P,    D_TM);
      6'd21: u = mk(K_SET, M_LD,  A_P,    B_P,    S_MN);
      6'd22: u = mk(K_MUL, M_SUB, A_PQ,   B_YX,   3'd0);
      6'd23: u = mk(K_MUL, M_SUB, A_QR,   B_IXZ,  3'd0);
      6'd24: u = mk(K_ST,  M_LD,  A_P,    B_P,    D_TN);
      6'd25: u = mk(K_MUL, M_LD,  A_TL,   B_IZZ,  3'd0);
      6'd26: u = mk(K_MUL, M_ADD, A_TN,   B_IXZ,  3'd0);
      6'd27: u = mk(K_DIV, M_LD,  A_P,    B_P,    3'd0);
      6'd28: u = mk(K_SET, M_LD,  A_P,    B_P,    S_TM);
      6'd29: u = mk(K_DIV, M_LD,  A_P,    B_P,    3'd1);
      6'd30: u = mk(K_MUL, M_LD,  A_TN,   B_IXX,  3'd0);
      6'd31: u = mk(K_MUL, M_ADD, A_TL,   B_IXZ,  3'd0);
      6'd32: u = mk(K_DIV, M_LD,  A_P,    B_P,    3'd2);
      6'd33: u = mk(K_MUL, M_LD,  A_SUM0, B_STEP, 3'd0);
      6'd34: u = mk(K_UPD, M_LD,  A_P,    B_P,    3'd0);
      6'd35: u = mk(K_MUL, M_LD,  A_SUM1, B_STEP, 3'd0);
      6'd36: u = mk(K_UPD, M_LD,  A_P,    B_P,    3'd1);
      6'd37: u = mk(K_MUL, M_LD,  A_SUM2, B_STEP, 3'd0);
      6'd38: u = mk(K_UPD, M_LD,  A_P,    B_P,    3'd2);
      default: u = mk(K_END, M_LD, A_P,   B_P,    3'd0);
    endcase
    return u;
  endfunction

endpackage

/* hdl/body_rate_euler_integrator_top.sv */
// Body-rate integrator: Euler rotational equations with trapezoidal rate update.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | roll/pitch/yaw_moment_i (s48, Q32.16)
//  out     | output    | out_valid_o/out_ready_i| roll/pitch/yaw_rate_o (s32, Q8.24), status_o
//  cfg     | input     | cfg_we_i             | cfg_index_i, cfg_data_i (48b)
//
//  An item runs through a 40-step micro-program on one 65x8 multiply unit and one restoring
//  divider (1 bit per cycle).
//  in_ready_o is high only while the sequencer is idle. A finished item waits in the output
//  register; the next item stalls at its last step while that one is not taken.
//  Reset clears rates, previous accelerations and loads the default inertias and step time.
module body_rate_euler_integrator_top import bre_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [MOM_W-1:0] roll_moment_i,
  input  logic signed [MOM_W-1:0] pitch_moment_i,
  input  logic signed [MOM_W-1:0] yaw_moment_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [RATE_W-1:0] roll_rate_o,
  output logic signed [RATE_W-1:0] pitch_rate_o,
  output logic signed [RATE_W-1:0] yaw_rate_o,
  output logic [STAT_W-1:0]       status_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_MACC = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DFIN = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  uop_t            uop;

  // configuration
  logic [INR_W-1:0]        ixx_q, iyy_q, izz_q;
  logic signed [INR_W-1:0] ixz_q;
  logic [STEP_W-1:0]       step_q;

  // architectural state
  logic signed [RATE_W-1:0] rate_q [3];
  logic signed [RATE_W-1:0] prev_q [3];
  logic signed [RATE_W-1:0] accn_q [3];

  // per-item working registers
  logic signed [MOM_W-1:0]  mom_q [3];
  logic signed [63:0]       pq_q, qr_q, pr_q, d2_q;
  logic signed [DEN_W-1:0]  den_q;
  logic signed [MOM_W-1:0]  tl_q, tm_q, tn_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     sing_q, sat_q;

  // multiply unit
  logic [MA_W-1:0]          ma_q;
  logic [MB_W-1:0]          mb_q;
  logic [PACC_W-1:0]        pacc_q;
  logic                     mneg_q;
  logic [2:0]               mcnt_q;

  // divide unit
  logic [NUM_W-1:0]         rem_q;
  logic [DSH_W-1:0]         dsh_q;
  logic [QUO_W-1:0]         quo_q;
  logic [4:0]               dcnt_q;
  logic                     dneg_q, big_q;

  // output register
  logic                     out_valid_q;
  logic signed [RATE_W-1:0] orate_q [3];
  logic [STAT_W-1:0]        ostat_q;

  assign uop = uop_rom(pc_q);

  // operand selection
  logic signed [32:0]       sum_ax [3];
  logic signed [INR_W:0]    d_zy, d_xz, d_yx;
  logic signed [MA_W-1:0]   a_op;
  logic signed [MBS_W-1:0]  b_op;

  for (genvar i = 0; i < 3; i++) begin : g_sum
    assign sum_ax[i] = 33'(prev_q[i]) + 33'(accn_q[i]);
  end

  assign d_zy = $signed({1'b0, izz_q}) - $signed({1'b0, iyy_q});
  assign d_xz = $signed({1'b0, ixx_q}) - $signed({1'b0, izz_q});
  assign d_yx = $signed({1'b0, iyy_q}) - $signed({1'b0, ixx_q});

  always_comb begin
    unique case (uop.asel)
      A_P:     a_op = MA_W'(rate_q[0]);
      A_Q:     a_op = MA_W'(rate_q[1]);
      A_R:     a_op = MA_W'(rate_q[2]);
      A_PQ:    a_op = MA_W'(pq_q);
      A_QR:    a_op = MA_W'(qr_q);
      A_PR:    a_op = MA_W'(pr_q);
      A_D2:    a_op = MA_W'(d2_q);
      A_IXX:   a_op = $signed(MA_W'(ixx_q));
      A_IXZ:   a_op = MA_W'(ixz_q);
      A_TL:    a_op = MA_W'(tl_q);
      A_TN:    a_op = MA_W'(tn_q);
      A_SUM0:  a_op = MA_W'(sum_ax[0]);
      A_SUM1:  a_op = MA_W'(sum_ax[1]);
      A_SUM2:  a_op = MA_W'(sum_ax[2]);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    unique case (uop.bsel)
      B_P:     b_op = MBS_W'(rate_q[0]);
      B_Q:     b_op = MBS_W'(rate_q[1]);
      B_R:     b_op = MBS_W'(rate_q[2]);
      B_IXX:   b_op = $signed(MBS_W'(ixx_q));
      B_IZZ:   b_op = $signed(MBS_W'(izz_q));
      B_IXZ:   b_op = MBS_W'(ixz_q);
      B_ZY:    b_op = MBS_W'(d_zy);
      B_XZ:    b_op = MBS_W'(d_xz);
      B_YX:    b_op = MBS_W'(d_yx);
      B_STEP:  b_op = $signed(MBS_W'(step_q));
      default: b_op = '0;
    endcase
  end

  // multiply: sign/magnitude, one 8-bit digit of B per cycle from the top
  logic signed [MA_W-1:0]   a_abs;
  logic signed [MBS_W-1:0]  b_abs;
  logic [MA_W+DIG_W-1:0]    mpart;
  logic signed [ACC_W-1:0]  prod;

  assign a_abs = a_op[MA_W-1] ? -a_op : a_op;
  assign b_abs = b_op[MBS_W-1] ? -b_op : b_op;
  assign mpart = ma_q * mb_q[MB_W-1 -: DIG_W];
  assign prod  = mneg_q ? -$signed({2'b00, pacc_q}) : $signed({2'b00, pacc_q});

  // divide setup: numerator is acc << 24, divisor is D or Iyy
  logic signed [ACC_W-1:0]  acc_abs;
  logic [NUM_W-1:0]         nmag;
  logic signed [DEN_W-1:0]  dsel, dabs;
  logic                     div_big, div_ge;
  logic signed [RATE_W-1:0] qv;

  assign acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign nmag    = {acc_abs[DEN_W-1:0], 24'd0};
  assign dsel    = (uop.arg[1:0] == 2'd1) ? $signed(DEN_W'(iyy_q)) : den_q;
  assign dabs    = dsel[DEN_W-1] ? -dsel : dsel;
  assign div_big = {8'd0, nmag} >= {dabs, 32'd0};
  assign div_ge  = {7'd0, rem_q} >= dsh_q;

  // truncated quotient, clipped to 32 bits
  always_comb begin
    if (dneg_q) begin
      if (big_q || quo_q > 32'h8000_0000) qv = 32'sh8000_0000;
      else                                 qv = 32'(-$signed({1'b0, quo_q}));
    end else begin
      if (big_q || quo_q[QUO_W-1]) qv = 32'sh7fff_ffff;
      else                          qv = $signed(quo_q);
    end
  end

  // torque: floor by 48 then clip to 48 bits
  logic signed [ACC_W-49:0] tsh;
  logic signed [MOM_W-1:0]  tclip;
  assign tsh = acc_q[ACC_W-1:48];
  always_comb begin
    if ((&tsh[ACC_W-49:MOM_W-1]) || !(|tsh[ACC_W-49:MOM_W-1])) tclip = tsh[MOM_W-1:0];
    else if (tsh[ACC_W-49])                                   tclip = {1'b1, 47'd0};
    else                                                      tclip = {1'b0, {47{1'b1}}};
  end

  // rate update: increment = (prev + accel) * dt >>> 25, clipped sum
  logic signed [32:0]       inc;
  logic signed [33:0]       rsum;
  logic signed [RATE_W-1:0] rclip;
  logic                     rsat;
  assign inc  = acc_q[57:25];
  assign rsum = 34'(rate_q[uop.arg[1:0]]) + 34'(inc);
  always_comb begin
    rsat = !((&rsum[33:31]) || !(|rsum[33:31]));
    if (!rsat)        rclip = rsum[31:0];
    else if (rsum[33]) rclip = 32'sh8000_0000;
    else              rclip = 32'sh7fff_ffff;
  end

  logic in_acc, out_free;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          pc_d    = '0;
        end
      end
      ST_RUN: begin
        unique case (uop.kind)
          K_MUL: state_d = ST_MUL;
          K_DIV: state_d = ST_DIV;
          K_CHK: pc_d = (den_q == '0 || iyy_q == '0) ? PC_END : pc_q + 1'b1;
          K_END: begin
            if (out_free) state_d = ST_IDLE;
          end
          default: pc_d = pc_q + 1'b1;
        endcase
      end
      ST_MUL: begin
        if (mcnt_q == 3'(MUL_STEPS - 1)) state_d = ST_MACC;
      end
      ST_MACC: begin
        state_d = ST_RUN;
        pc_d    = pc_q + 1'b1;
      end
      ST_DIV: begin
        if (dcnt_q == 5'(QUO_W - 1)) state_d = ST_DFIN;
      end
      ST_DFIN: begin
        state_d = ST_RUN;
        pc_d    = pc_q + 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      ixx_q       <= INR_RST;
      iyy_q       <= INR_RST;
      izz_q       <= INR_RST;
      ixz_q       <= '0;
      step_q      <= STEP_RST;
      for (int i = 0; i < 3; i++) begin
        rate_q[i] <= '0;
        prev_q[i] <= '0;
      end
      sing_q      <= 1'b0;
      sat_q       <= 1'b0;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_IXX:  ixx_q  <= cfg_data_i;
          CFG_IYY:  iyy_q  <= cfg_data_i;
          CFG_IZZ:  izz_q  <= cfg_data_i;
          CFG_IXZ:  ixz_q  <= $signed(cfg_data_i);
          CFG_STEP: step_q <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end

      // a new item loads the output register, else a taken one empties it
      if (state_q == ST_RUN && uop.kind == K_END && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i)                     out_valid_q <= 1'b0;

      if (in_acc) begin
        sing_q <= 1'b0;
        sat_q  <= 1'b0;
      end

      if (state_q == ST_RUN) begin
        if (uop.kind == K_MUL) mcnt_q <= '0;
        if (uop.kind == K_DIV) dcnt_q <= '0;
        if (uop.kind == K_CHK && (den_q == '0 || iyy_q == '0)) sing_q <= 1'b1;
        if (uop.kind == K_UPD) begin
          rate_q[uop.arg[1:0]] <= rclip;
          prev_q[uop.arg[1:0]] <= accn_q[uop.arg[1:0]];
          if (rsat) sat_q <= 1'b1;
        end
      end
      if (state_q == ST_MUL) mcnt_q <= mcnt_q + 1'b1;
      if (state_q == ST_DIV) dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mom_q[0] <= roll_moment_i;
      mom_q[1] <= pitch_moment_i;
      mom_q[2] <= yaw_moment_i;
    end

    if (state_q == ST_RUN) begin
      unique case (uop.kind)
        K_MUL: begin
          ma_q   <= a_abs;
          mb_q   <= {{(MB_W - MBS_W){1'b0}}, b_abs};
          mneg_q <= a_op[MA_W-1] ^ b_op[MBS_W-1];
          pacc_q <= '0;
        end
        K_SET: begin
          unique case (uop.arg)
            S_ML:    acc_q <= {{(ACC_W - 96){mom_q[0][MOM_W-1]}}, mom_q[0], 48'd0};
            S_MM:    acc_q <= {{(ACC_W - 96){mom_q[1][MOM_W-1]}}, mom_q[1], 48'd0};
            S_MN:    acc_q <= {{(ACC_W - 96){mom_q[2][MOM_W-1]}}, mom_q[2], 48'd0};
            default: acc_q <= ACC_W'(tm_q);
          endcase
        end
        K_ST: begin
          unique case (uop.arg)
            D_PQ:  pq_q  <= acc_q[63:0];
            D_QR:  qr_q  <= acc_q[63:0];
            D_PR:  pr_q  <= acc_q[63:0];
            D_D2:  d2_q  <= acc_q[63:0];
            D_DEN: den_q <= acc_q[DEN_W-1:0];
            D_TL:  tl_q  <= tclip;
            D_TM:  tm_q  <= tclip;
            D_TN:  tn_q  <= tclip;
            default: ;
          endcase
        end
        K_DIV: begin
          rem_q  <= nmag;
          dsh_q  <= {dabs, 31'd0};
          quo_q  <= '0;
          dneg_q <= acc_q[ACC_W-1] ^ dsel[DEN_W-1];
          big_q  <= div_big;
        end
        K_END: begin
          if (out_free) begin
            for (int i = 0; i < 3; i++) orate_q[i] <= rate_q[i];
            ostat_q <= sing_q ? STAT_SING : (sat_q ? STAT_SAT : STAT_OK);
          end
        end
        default: ;
      endcase
    end

    if (state_q == ST_MUL) begin
      pacc_q <= {pacc_q[PACC_W-DIG_W-1:0], {DIG_W{1'b0}}} + PACC_W'(mpart);
      mb_q   <= {mb_q[MB_W-DIG_W-1:0], {DIG_W{1'b0}}};
    end

    if (state_q == ST_MACC) begin
      unique case (uop.mode)
        M_ADD:   acc_q <= acc_q + prod;
        M_SUB:   acc_q <= acc_q - prod;
        default: acc_q <= prod;
      endcase
    end

    if (state_q == ST_DIV) begin
      if (div_ge) rem_q <= rem_q - dsh_q[NUM_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
      dsh_q <= dsh_q >> 1;
    end

    if (state_q == ST_DFIN) accn_q[uop.arg[1:0]] <= qv;
  end

  assign out_valid_o  = out_valid_q;
  assign roll_rate_o  = orate_q[0];
  assign pitch_rate_o = orate_q[1];
  assign yaw_rate_o   = orate_q[2];
  assign status_o     = ostat_q;

  // an accepted item keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // a singular item reports the rates the block still holds
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && status_o == STAT_SING) |->
      (roll_rate_o == rate_q[0] && pitch_rate_o == rate_q[1] && yaw_rate_o == rate_q[2]))
    else $error("singular item changed the rates");

  a_mcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (mcnt_q < 3'(MUL_STEPS)))
    else $error("multiply digit count overran");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != STAT_RSVD))
    else $error("reserved status code");

endmodule
